FILE: hw/rtl/dmac_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dmac_pkg
// Shared types and codes for the distinct address collector: request and
// response structs, opcode/status/frame codes, controller states.
// ---------------------------------------------------------------------------
package dmac_pkg;

  // Default table depth and register reset value
  localparam int unsigned CAPACITY_DEF = 64;
  localparam logic [6:0]  MAX_ENTRIES_RST = 7'd64;

  // Request opcodes
  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Frame types (only management frames are collected)
  localparam logic [1:0] FT_MGMT = 2'd0;

  // Response status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_IGNORED   = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;
  localparam logic [2:0] ST_READ_OK   = 3'd5;
  localparam logic [2:0] ST_BAD_INDEX = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  frame_type;
    logic [47:0] source_mac;
    logic [5:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  entry_count;
    logic [47:0] entry_mac;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/distinct_mac_address_collector_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// distinct_mac_address_collector_top
// Collects distinct source addresses of management frames into a table held
// in a synchronous RAM, searched linearly one entry per cycle.
// ---------------------------------------------------------------------------
//  Channel | Ports                      | Direction | Handshake
//  --------+----------------------------+-----------+------------------
//  in      | in_valid in_ready in_req   | input     | valid/ready
//  out     | out_valid out_ready out_rsp| output    | valid/ready
//  cfg     | cfg_we cfg_wdata           | input     | write enable only
//
// An observe request for a management frame with room in the table walks
// all stored entries in S_SEARCH, one RAM read per stored entry, set by the
// single read port, before it moves to S_DONE. A read of a stored entry
// passes through S_READ to S_DONE; any other request goes straight to
// S_DONE. Reset empties the table at once (count to zero) and sets
// max_entries to 64. The next request is taken while a response waits in
// the output register; a stalled output holds the controller in its final
// state.
// ---------------------------------------------------------------------------
module distinct_mac_address_collector_top
  import dmac_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire req_t       in_req,
  output logic            out_valid,
  input  wire logic       out_ready,
  output rsp_t            out_rsp,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > 7) ? CW : 7;
  localparam int unsigned IW = (AW > 6) ? AW : 6;

  // Address table
  logic [47:0] mem [CAPACITY];
  logic [47:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  ptr_r, ptr_nxt;
  logic           pend_r, pend_nxt;
  logic           hit_r, hit_nxt;
  logic [6:0]     max_r;
  req_t           req_r, req_nxt;
  rsp_t           res_r, res_nxt;
  logic           out_valid_r, out_valid_nxt;
  rsp_t           out_rsp_r, out_rsp_nxt;

  logic [LW-1:0]  lim;
  logic           full;
  logic           in_range;
  logic [IW-1:0]  idx_ext;
  logic           cmp_hit;

  // Effective limit is the smaller of max_entries and the table depth
  always_comb begin
    if (LW'(max_r) > LW'(CAPACITY)) begin
      lim = LW'(CAPACITY);
    end else begin
      lim = LW'(max_r);
    end
  end

  assign full     = (LW'(cnt_r) >= lim);
  assign in_range = (LW'(in_req.read_index) < LW'(cnt_r));
  assign idx_ext  = IW'(in_req.read_index);
  assign cmp_hit  = pend_r && (rd_data_r == req_r.source_mac);

  // RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[AW-1:0]] <= req_r.source_mac;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      max_r       <= MAX_ENTRIES_RST;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    hit_nxt       = hit_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_rsp_nxt   = out_rsp_r;
    out_valid_nxt = out_valid_r;
    rd_addr       = ptr_r[AW-1:0];
    wr_en         = 1'b0;
    in_ready      = 1'b0;

    // output register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt             = in_req;
          res_nxt.entry_mac   = '0;
          res_nxt.entry_count = '0;
          state_nxt           = S_DONE;
          case (in_req.opcode)
            OP_OBSERVE: begin
              if (in_req.frame_type != FT_MGMT) begin
                res_nxt.status = ST_IGNORED;
              end else if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                ptr_nxt   = '0;
                pend_nxt  = 1'b0;
                hit_nxt   = 1'b0;
                state_nxt = S_SEARCH;
              end
            end
            OP_CLEAR: begin
              cnt_nxt        = '0;
              res_nxt.status = ST_CLEARED;
            end
            OP_READ: begin
              if (in_range) begin
                rd_addr   = idx_ext[AW-1:0];
                state_nxt = S_READ;
              end else begin
                res_nxt.status = ST_BAD_INDEX;
              end
            end
            default: begin
              res_nxt.status = ST_IGNORED;
            end
          endcase
        end
      end

      // issue one read per cycle, compare the registered read data
      S_SEARCH: begin
        hit_nxt = hit_r | cmp_hit;
        if (ptr_r < cnt_r) begin
          rd_addr  = ptr_r[AW-1:0];
          ptr_nxt  = ptr_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
            if (hit_r) begin
              res_nxt.status = ST_DUPLICATE;
            end else begin
              wr_en          = 1'b1;
              cnt_nxt        = cnt_r + CW'(1);
              res_nxt.status = ST_ADDED;
            end
          end
        end
      end

      S_READ: begin
        res_nxt.status    = ST_READ_OK;
        res_nxt.entry_mac = rd_data_r;
        state_nxt         = S_DONE;
      end

      // hand the response to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_rsp_nxt             = res_r;
          out_rsp_nxt.entry_count = 7'(cnt_r);
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire
